/* rtl/tfch_pkg.sv */
// ----------------------------------------------------------------------------
// Tilt-frame compass package
// Shared widths, command and status codes, item types and the CORDIC angle
// table of the tilt-compensated compass heading block.
// ----------------------------------------------------------------------------
package tfch_pkg;

  localparam int unsigned CalSamplesMax  = 1024;
  localparam int unsigned CordicStepsCfg = 16;
  localparam int unsigned AngTableLen    = 24;
  localparam int unsigned CordicSteps    =
    (CordicStepsCfg > AngTableLen) ? AngTableLen : CordicStepsCfg;

  localparam int unsigned InW    = 16;
  localparam int unsigned CntW   = $clog2(CalSamplesMax + 1);
  localparam int unsigned SumW   = InW + CntW;
  localparam int unsigned CompW  = 31;
  localparam int unsigned AxW    = 16;
  localparam int unsigned QFracW = 14;
  localparam int unsigned MulW   = 32;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned SqW    = 62;
  localparam int unsigned LenW   = 31;
  localparam int unsigned DivNW  = 45;
  localparam int unsigned DivDW  = LenW;
  localparam int unsigned DivQW  = 17;
  localparam int unsigned DivCntW = $clog2(DivNW);
  localparam int unsigned ProjW  = 33;
  localparam int unsigned CordW  = 36;
  localparam int unsigned AngW   = 33;
  localparam int unsigned AngFracW = 16;
  localparam int unsigned IdxW   = $clog2(AngTableLen);
  localparam int unsigned HeadW  = 15;
  localparam int unsigned RateW  = 17;

  localparam int unsigned HalfTurn = 11520;
  localparam logic signed [AngW-1:0] HalfAng = AngW'(64'(HalfTurn) << AngFracW);

  localparam logic [2:0] CmdAccel   = 3'd0;
  localparam logic [2:0] CmdMag     = 3'd1;
  localparam logic [2:0] CmdGyro    = 3'd2;
  localparam logic [2:0] CmdFinish  = 3'd3;
  localparam logic [2:0] CmdMeasure = 3'd4;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatUncal = 2'd1;
  localparam logic [1:0] StatDegen = 2'd2;

  typedef enum logic [2:0] {
    OP_ACCEL,
    OP_MAG,
    OP_GYRO,
    OP_FINISH,
    OP_MEASURE
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic signed [InW-1:0] x;
    logic signed [InW-1:0] y;
    logic signed [InW-1:0] z;
    logic signed [InW-1:0] rate_z;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_t;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] num;
    logic [DivDW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivQW-1:0] quo;
  } div_rsp_t;

  // atan(2^-i) in 1/64 degree with 16 fraction bits.
  function automatic logic signed [AngW-1:0] ang_of(input logic [IdxW-1:0] i);
    logic signed [AngW-1:0] a;
    unique case (i)
      5'd0:  a = 33'sd188743680;
      5'd1:  a = 33'sd111421900;
      5'd2:  a = 33'sd58872272;
      5'd3:  a = 33'sd29884485;
      5'd4:  a = 33'sd15000234;
      5'd5:  a = 33'sd7507429;
      5'd6:  a = 33'sd3754631;
      5'd7:  a = 33'sd1877430;
      5'd8:  a = 33'sd938729;
      5'd9:  a = 33'sd469366;
      5'd10: a = 33'sd234683;
      5'd11: a = 33'sd117342;
      5'd12: a = 33'sd58671;
      5'd13: a = 33'sd29335;
      5'd14: a = 33'sd14668;
      5'd15: a = 33'sd7334;
      5'd16: a = 33'sd3667;
      5'd17: a = 33'sd1833;
      5'd18: a = 33'sd917;
      5'd19: a = 33'sd458;
      5'd20: a = 33'sd229;
      5'd21: a = 33'sd115;
      5'd22: a = 33'sd57;
      5'd23: a = 33'sd29;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/tfch_div.sv */
// ----------------------------------------------------------------------------
// Tilt-frame compass divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfch_div import tfch_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNW-1:0]   num_q, num_d;
  logic [DivDW-1:0]   den_q, den_d;
  logic [DivDW-1:0]   rem_q, rem_d;
  logic [DivQW-1:0]   quo_q, quo_d;
  logic [DivDW:0]     trial;
  logic [DivDW:0]     diff;
  logic               ge;

  assign trial = {rem_q, num_q[DivNW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivNW - 1);
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivDW-1:0] : trial[DivDW-1:0];
      quo_d = {quo_q[DivQW-2:0], ge};
      num_d = {num_q[DivNW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* rtl/tfch_front.sv */
// ----------------------------------------------------------------------------
// Tilt-frame compass front end
// Accepts command items, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tfch_front import tfch_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [2:0]            cmd_i,
  input  logic signed [InW-1:0] x_i,
  input  logic signed [InW-1:0] y_i,
  input  logic signed [InW-1:0] z_i,
  input  logic signed [InW-1:0] rate_z_i,
  output fq_t                   fq_o,
  input  logic                  pop_i
);

  item_t      mem_q [2];
  item_t      item;
  logic       keep;
  logic       push;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_comb begin
    keep    = 1'b1;
    item.op = OP_ACCEL;
    unique case (cmd_i)
      CmdAccel:   item.op = OP_ACCEL;
      CmdMag:     item.op = OP_MAG;
      CmdGyro:    item.op = OP_GYRO;
      CmdFinish:  item.op = OP_FINISH;
      CmdMeasure: item.op = OP_MEASURE;
      default:    keep = 1'b0;
    endcase
    item.x      = x_i;
    item.y      = y_i;
    item.z      = z_i;
    item.rate_z = rate_z_i;
  end

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item;
    end
  end

  assign fq_o.valid = (cnt_q != 2'd0);
  assign fq_o.item  = mem_q[rd_q];

endmodule

/* rtl/tfch_back.sv */
// ----------------------------------------------------------------------------
// Tilt-frame compass back end
// Sequencer with a shared multiplier, square root, divider port and CORDIC
// that accumulates samples, builds the frame and produces headings.
// ----------------------------------------------------------------------------
module tfch_back import tfch_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fq_t                     fq_i,
  output logic                    pop_o,
  output div_req_t                div_req_o,
  input  div_rsp_t                div_rsp_i,
  output logic                    valid_o,
  output logic signed [HeadW-1:0] heading_o,
  output logic signed [RateW-1:0] rate_o,
  output logic [1:0]              status_o
);

  typedef enum logic [16:0] {
    ST_IDLE    = 17'h00001,
    ST_LOAD    = 17'h00002,
    ST_CR_MUL  = 17'h00004,
    ST_CR_ACC  = 17'h00008,
    ST_SQ_MUL  = 17'h00010,
    ST_SQ_ACC  = 17'h00020,
    ST_SQRT    = 17'h00040,
    ST_N_START = 17'h00080,
    ST_N_WAIT  = 17'h00100,
    ST_G_START = 17'h00200,
    ST_G_WAIT  = 17'h00400,
    ST_F_DONE  = 17'h00800,
    ST_M_MUL   = 17'h01000,
    ST_M_ACC   = 17'h02000,
    ST_M_PRE   = 17'h04000,
    ST_CORDIC  = 17'h08000,
    ST_M_RND   = 17'h10000
  } state_e;

  state_e                  state_q, state_d;
  logic [2:0]              k_q, k_d;
  logic [1:0]              vec_q, vec_d;
  logic                    ok_q, ok_d;
  logic signed [CompW-1:0] c_q [3];
  logic signed [CompW-1:0] c_d [3];
  logic signed [AxW-1:0]   zax_q [3];
  logic signed [AxW-1:0]   zax_d [3];
  logic signed [AxW-1:0]   xax_q [3];
  logic signed [AxW-1:0]   xax_d [3];
  logic signed [AxW-1:0]   yax_q [3];
  logic signed [AxW-1:0]   yax_d [3];
  logic signed [AxW-1:0]   frame_q [6];
  logic signed [AxW-1:0]   frame_d [6];
  logic signed [SumW-1:0]  asum_q [3];
  logic signed [SumW-1:0]  asum_d [3];
  logic signed [SumW-1:0]  msum_q [3];
  logic signed [SumW-1:0]  msum_d [3];
  logic signed [SumW-1:0]  gsum_q, gsum_d;
  logic [CntW-1:0]         cnt_q [3];
  logic [CntW-1:0]         cnt_d [3];
  logic signed [InW-1:0]   goff_q, goff_d;
  logic                    cal_q, cal_d;
  logic                    deg_q, deg_d;
  logic signed [ProdW-1:0] prod_q;
  logic [SqW-1:0]          sq_q, sq_d;
  logic [SqW-1:0]          res_q, res_d;
  logic [SqW-1:0]          bit_q, bit_d;
  logic signed [InW-1:0]   mv_q [3];
  logic signed [InW-1:0]   mv_d [3];
  logic signed [InW-1:0]   mrate_q, mrate_d;
  logic signed [ProjW-1:0] rx_q, rx_d;
  logic signed [ProjW-1:0] ry_q, ry_d;
  logic signed [CordW-1:0] xv_q, xv_d;
  logic signed [CordW-1:0] yv_q, yv_d;
  logic signed [AngW-1:0]  ang_q, ang_d;
  logic [IdxW-1:0]         i_q, i_d;
  logic                    valid_q, valid_d;
  logic signed [HeadW-1:0] head_q, head_d;
  logic signed [RateW-1:0] rate_q, rate_d;
  logic [1:0]              stat_q, stat_d;

  logic signed [MulW-1:0]  mul_a, mul_b;
  logic [1:0]              ia, ib, mi;
  logic signed [AxW-1:0]   av [3];
  logic signed [AxW-1:0]   bv [3];
  logic [LenW-1:0]         len;
  logic [SqW-1:0]          trial;
  logic [CompW-1:0]        cabs;
  logic signed [AxW-1:0]   nval;
  logic signed [AxW-1:0]   nsel;
  logic [SumW-1:0]         gabs;
  logic signed [RateW-1:0] gq;
  logic signed [CordW-1:0] shx, shy;
  logic [AngW-1:0]         ang_abs;
  logic [AngW-1:0]         hq;
  logic [HeadW-1:0]        hmag;
  logic [1:0]              stat_now;

  assign len   = res_q[LenW-1:0];
  assign trial = res_q + bit_q;
  assign cabs  = c_q[k_q[1:0]][CompW-1] ? CompW'(-c_q[k_q[1:0]]) : CompW'(c_q[k_q[1:0]]);
  assign gabs  = gsum_q[SumW-1] ? SumW'(-gsum_q) : SumW'(gsum_q);
  assign shx   = xv_q >>> i_q;
  assign shy   = yv_q >>> i_q;
  assign stat_now = !cal_q ? StatUncal : (deg_q ? StatDegen : StatOk);

  always_comb begin
    nval = c_q[k_q[1:0]][CompW-1] ? -$signed(div_rsp_i.quo[AxW-1:0])
                                  : $signed(div_rsp_i.quo[AxW-1:0]);
    nsel = (len == '0) ? '0 : nval;
    gq   = gsum_q[SumW-1] ? -$signed({1'b0, div_rsp_i.quo[InW-1:0]})
                          : $signed({1'b0, div_rsp_i.quo[InW-1:0]});
    ang_abs = ang_q[AngW-1] ? AngW'(-ang_q) : AngW'(ang_q);
    hq      = (ang_abs + AngW'(1 << (AngFracW - 1))) >> AngFracW;
    hmag    = (hq > AngW'(HalfTurn)) ? HeadW'(HalfTurn) : hq[HeadW-1:0];
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      av[n] = (vec_q == 2'd2) ? zax_q[n] : yax_q[n];
      bv[n] = (vec_q == 2'd2) ? xax_q[n] : zax_q[n];
    end
    ia = 2'd0;
    ib = 2'd0;
    unique case (k_q)
      3'd0: begin ia = 2'd1; ib = 2'd2; end
      3'd1: begin ia = 2'd2; ib = 2'd1; end
      3'd2: begin ia = 2'd2; ib = 2'd0; end
      3'd3: begin ia = 2'd0; ib = 2'd2; end
      3'd4: begin ia = 2'd0; ib = 2'd1; end
      3'd5: begin ia = 2'd1; ib = 2'd0; end
      default: begin ia = 2'd0; ib = 2'd0; end
    endcase
    mi    = (k_q < 3'd3) ? k_q[1:0] : 2'(k_q - 3'd3);
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_CR_MUL) begin
      mul_a = MulW'(av[ia]);
      mul_b = MulW'(bv[ib]);
    end else if (state_q == ST_SQ_MUL) begin
      mul_a = MulW'(c_q[k_q[1:0]]);
      mul_b = MulW'(c_q[k_q[1:0]]);
    end else if (state_q == ST_M_MUL) begin
      mul_a = MulW'(mv_q[mi]);
      mul_b = MulW'(frame_q[k_q]);
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    vec_d   = vec_q;
    ok_d    = ok_q;
    c_d     = c_q;
    zax_d   = zax_q;
    xax_d   = xax_q;
    yax_d   = yax_q;
    frame_d = frame_q;
    asum_d  = asum_q;
    msum_d  = msum_q;
    gsum_d  = gsum_q;
    cnt_d   = cnt_q;
    goff_d  = goff_q;
    cal_d   = cal_q;
    deg_d   = deg_q;
    sq_d    = sq_q;
    res_d   = res_q;
    bit_d   = bit_q;
    mv_d    = mv_q;
    mrate_d = mrate_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    xv_d    = xv_q;
    yv_d    = yv_q;
    ang_d   = ang_q;
    i_d     = i_q;
    valid_d = 1'b0;
    head_d  = head_q;
    rate_d  = rate_q;
    stat_d  = stat_q;
    pop_o   = 1'b0;
    div_req_o.start = 1'b0;
    div_req_o.num   = (DivNW'(cabs) << QFracW) + DivNW'(len >> 1);
    div_req_o.den   = len;

    unique case (state_q)
      ST_IDLE: begin
        if (fq_i.valid) begin
          pop_o = 1'b1;
          case (fq_i.item.op)
            OP_ACCEL: begin
              if (cnt_q[0] < CntW'(CalSamplesMax)) begin
                asum_d[0] = asum_q[0] + SumW'(fq_i.item.x);
                asum_d[1] = asum_q[1] + SumW'(fq_i.item.y);
                asum_d[2] = asum_q[2] + SumW'(fq_i.item.z);
                cnt_d[0]  = cnt_q[0] + 1'b1;
              end
            end
            OP_MAG: begin
              if (cnt_q[1] < CntW'(CalSamplesMax)) begin
                msum_d[0] = msum_q[0] + SumW'(fq_i.item.x);
                msum_d[1] = msum_q[1] + SumW'(fq_i.item.y);
                msum_d[2] = msum_q[2] + SumW'(fq_i.item.z);
                cnt_d[1]  = cnt_q[1] + 1'b1;
              end
            end
            OP_GYRO: begin
              if (cnt_q[2] < CntW'(CalSamplesMax)) begin
                gsum_d   = gsum_q + SumW'(fq_i.item.z);
                cnt_d[2] = cnt_q[2] + 1'b1;
              end
            end
            OP_FINISH: begin
              vec_d   = 2'd0;
              ok_d    = 1'b1;
              state_d = ST_LOAD;
            end
            default: begin
              mv_d[0] = fq_i.item.x;
              mv_d[1] = fq_i.item.y;
              mv_d[2] = fq_i.item.z;
              mrate_d = fq_i.item.rate_z;
              rx_d    = '0;
              ry_d    = '0;
              k_d     = '0;
              state_d = ST_M_MUL;
            end
          endcase
        end
      end
      ST_LOAD: begin
        k_d  = '0;
        sq_d = '0;
        for (int n = 0; n < 3; n++) begin
          if (vec_q == 2'd0) begin
            c_d[n] = CompW'(asum_q[n]);
          end else if (vec_q == 2'd1) begin
            c_d[n] = CompW'(msum_q[n]);
          end else begin
            c_d[n] = '0;
          end
        end
        state_d = vec_q[1] ? ST_CR_MUL : ST_SQ_MUL;
      end
      ST_CR_MUL: state_d = ST_CR_ACC;
      ST_CR_ACC: begin
        if (k_q[0]) begin
          c_d[k_q[2:1]] = c_q[k_q[2:1]] - CompW'(prod_q);
        end else begin
          c_d[k_q[2:1]] = c_q[k_q[2:1]] + CompW'(prod_q);
        end
        if (k_q == 3'd5) begin
          k_d     = '0;
          state_d = ST_SQ_MUL;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_CR_MUL;
        end
      end
      ST_SQ_MUL: state_d = ST_SQ_ACC;
      ST_SQ_ACC: begin
        sq_d = sq_q + prod_q[SqW-1:0];
        if (k_q == 3'd2) begin
          res_d   = '0;
          bit_d   = SqW'(1) << (SqW - 2);
          state_d = ST_SQRT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_SQ_MUL;
        end
      end
      ST_SQRT: begin
        if (sq_q >= trial) begin
          sq_d  = sq_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == SqW'(1)) begin
          k_d     = '0;
          state_d = ST_N_START;
        end
      end
      ST_N_START, ST_N_WAIT: begin
        if (state_q == ST_N_START && len != '0) begin
          div_req_o.start = 1'b1;
          state_d         = ST_N_WAIT;
        end else if (state_q == ST_N_START || div_rsp_i.done) begin
          if (len == '0) begin
            ok_d = 1'b0;
          end
          unique case (vec_q)
            2'd0:    zax_d[k_q[1:0]] = nsel;
            2'd2:    yax_d[k_q[1:0]] = nsel;
            default: xax_d[k_q[1:0]] = nsel;
          endcase
          if (k_q == 3'd2) begin
            k_d = '0;
            if (vec_q == 2'd3) begin
              state_d = ST_G_START;
            end else begin
              vec_d   = vec_q + 1'b1;
              state_d = ST_LOAD;
            end
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_N_START;
          end
        end
      end
      ST_G_START: begin
        if (cnt_q[2] == '0) begin
          goff_d  = '0;
          state_d = ST_F_DONE;
        end else begin
          div_req_o.start = 1'b1;
          div_req_o.num   = DivNW'(gabs) + DivNW'(cnt_q[2] >> 1);
          div_req_o.den   = DivDW'(cnt_q[2]);
          state_d         = ST_G_WAIT;
        end
      end
      ST_G_WAIT: begin
        if (div_rsp_i.done) begin
          goff_d  = gq[InW-1:0];
          state_d = ST_F_DONE;
        end
      end
      ST_F_DONE: begin
        for (int n = 0; n < 3; n++) begin
          frame_d[n]     = ok_q ? xax_q[n] : '0;
          frame_d[3 + n] = ok_q ? yax_q[n] : '0;
          asum_d[n]      = '0;
          msum_d[n]      = '0;
          cnt_d[n]       = '0;
        end
        gsum_d  = '0;
        deg_d   = !ok_q;
        cal_d   = 1'b1;
        state_d = ST_IDLE;
      end
      ST_M_MUL: state_d = ST_M_ACC;
      ST_M_ACC: begin
        if (k_q < 3'd3) begin
          rx_d = rx_q + ProjW'(prod_q);
        end else begin
          ry_d = ry_q + ProjW'(prod_q);
        end
        if (k_q == 3'd5) begin
          state_d = ST_M_PRE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_M_MUL;
        end
      end
      ST_M_PRE: begin
        rate_d = RateW'(mrate_q) - RateW'(goff_q);
        stat_d = stat_now;
        if (stat_now != StatOk || (rx_q == '0 && ry_q == '0)) begin
          head_d  = '0;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          i_d = '0;
          if (rx_q < 0) begin
            ang_d = (ry_q >= 0) ? HalfAng : -HalfAng;
            xv_d  = -CordW'(rx_q);
            yv_d  = -CordW'(ry_q);
          end else begin
            ang_d = '0;
            xv_d  = CordW'(rx_q);
            yv_d  = CordW'(ry_q);
          end
          state_d = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (yv_q > 0) begin
          xv_d  = xv_q + shy;
          yv_d  = yv_q - shx;
          ang_d = ang_q + ang_of(i_q);
        end else begin
          xv_d  = xv_q - shy;
          yv_d  = yv_q + shx;
          ang_d = ang_q - ang_of(i_q);
        end
        if (i_q == IdxW'(CordicSteps - 1)) begin
          state_d = ST_M_RND;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_M_RND: begin
        head_d  = ang_q[AngW-1] ? -$signed(hmag) : $signed(hmag);
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      vec_q   <= '0;
      ok_q    <= 1'b0;
      for (int n = 0; n < 3; n++) begin
        asum_q[n] <= '0;
        msum_q[n] <= '0;
        cnt_q[n]  <= '0;
      end
      for (int n = 0; n < 6; n++) begin
        frame_q[n] <= '0;
      end
      gsum_q  <= '0;
      goff_q  <= '0;
      cal_q   <= 1'b0;
      deg_q   <= 1'b0;
      i_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      vec_q   <= vec_d;
      ok_q    <= ok_d;
      asum_q  <= asum_d;
      msum_q  <= msum_d;
      cnt_q   <= cnt_d;
      frame_q <= frame_d;
      gsum_q  <= gsum_d;
      goff_q  <= goff_d;
      cal_q   <= cal_d;
      deg_q   <= deg_d;
      i_q     <= i_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q     <= c_d;
    zax_q   <= zax_d;
    xax_q   <= xax_d;
    yax_q   <= yax_d;
    prod_q  <= mul_a * mul_b;
    sq_q    <= sq_d;
    res_q   <= res_d;
    bit_q   <= bit_d;
    mv_q    <= mv_d;
    mrate_q <= mrate_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    xv_q    <= xv_d;
    yv_q    <= yv_d;
    ang_q   <= ang_d;
    head_q  <= head_d;
    rate_q  <= rate_d;
    stat_q  <= stat_d;
  end

  assign valid_o   = valid_q;
  assign heading_o = head_q;
  assign rate_o    = rate_q;
  assign status_o  = stat_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("Result strobe held for more than one cycle.");

  a_div_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == ST_N_WAIT || state_q == ST_G_WAIT))
    else $error("Divider finished while no quotient was awaited.");

  a_cordic_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORDIC) |-> (cal_q && !deg_q))
    else $error("Heading computed without a valid frame.");

endmodule

/* rtl/tilt_frame_compass_heading.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated compass heading
// Calibrates a rotation frame from accelerometer, magnetometer and gyro
// samples and turns each magnetometer sample into a heading.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge with start_i high and busy_o low. Items
// pass a two-entry queue, so busy_o rises only when both entries are full.
// Calibration samples are accumulated while the back end stays idle. A finish
// item runs four vector normalizations, two of them after a cross product,
// each a 31-step square root and three 45-step divisions, plus the gyro mean.
// A measure item occupies the back end for six shared multiplications and,
// with a usable frame and a nonzero projection, 16 CORDIC steps, and its
// result appears on valid_o, heading_o, rate_o and status_o for exactly one
// cycle. Other items give no result.
// The receiver cannot hold results off; each is presented once.
// Reset clears the sums, counts, frame, gyro offset and flags, so measure
// items report not calibrated until a finish item has been processed.
// ----------------------------------------------------------------------------
module tilt_frame_compass_heading import tfch_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [2:0]              cmd_i,
  input  logic signed [InW-1:0]   x_i,
  input  logic signed [InW-1:0]   y_i,
  input  logic signed [InW-1:0]   z_i,
  input  logic signed [InW-1:0]   rate_z_i,
  output logic                    valid_o,
  output logic signed [HeadW-1:0] heading_o,
  output logic signed [RateW-1:0] rate_o,
  output logic [1:0]              status_o
);

  fq_t      fq;
  logic     pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  tfch_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .cmd_i    (cmd_i),
    .x_i      (x_i),
    .y_i      (y_i),
    .z_i      (z_i),
    .rate_z_i (rate_z_i),
    .fq_o     (fq),
    .pop_i    (pop)
  );

  tfch_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tfch_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fq_i      (fq),
    .pop_o     (pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .valid_o   (valid_o),
    .heading_o (heading_o),
    .rate_o    (rate_o),
    .status_o  (status_o)
  );

endmodule
